// ===== hdl/rdxr_pkg.sv =====
// Package: shared types and constants for the rotary/DTMF extension ringer.
`timescale 1ns / 1ps

package rdxr_pkg;

    // Input word: one loop tick or one buzzer tick
    typedef struct packed {
        logic       mode;
        logic       pulse_level;
        logic       tone_strobe;
        logic [3:0] tone_code;
    } item_t;

    // Result word
    typedef struct packed {
        logic [3:0] selected_ext;
        logic [7:0] buzzer_lines;
        logic       status_led;
    } result_t;

    // Rotary dial modes
    typedef enum logic [1:0] {
        DIAL_IDLE  = 2'd0,
        DIAL_PULSE = 2'd1,
        DIAL_SPACE = 2'd2,
        DIAL_HELD  = 2'd3
    } dial_mode_t;

    // Tick kinds
    localparam logic MODE_MAIN   = 1'b0;
    localparam logic MODE_BUZZER = 1'b1;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MSECS_PER_TICK  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SPACE_MSECS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RING_MSECS      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLDOFF_MSECS   = 2'd3;
    localparam int CFG_DATA_W = 14;

    // Configuration reset values
    localparam logic [6:0]  MSECS_PER_TICK_RST       = 7'd2;
    localparam logic [9:0]  MAX_SPACE_MSECS_RST      = 10'd200;
    localparam logic [13:0] RING_MSECS_RST           = 14'd800;
    localparam logic [13:0] HOLDOFF_MSECS_RST        = 14'd500;

    // Timer limits
    localparam logic [13:0] UPTIME_STOP  = 14'd10000;
    localparam logic [10:0] PHASE_WRAP   = 11'd1000;
    localparam logic [9:0]  LED_ON1_END  = 10'd150;
    localparam logic [9:0]  LED_ON2_BEG  = 10'd300;
    localparam logic [9:0]  LED_ON2_END  = 10'd450;

    // Extension codes
    localparam logic [3:0] EXT_NONE = 4'd0;
    localparam logic [3:0] EXT_ALL  = 4'd10;
    localparam logic [3:0] PULSE_COUNT_MAX = 4'd15;

endpackage

// ===== hdl/rotary_dtmf_extension_ringer.sv =====
// Top level: extension selector from DTMF or rotary dial, buzzer lines and status LED.
`timescale 1ns / 1ps

//  channel  | signals                               | dir | handshake
//  ---------+---------------------------------------+-----+----------------------------
//  item     | item (item_t)                         | in  | item_valid / item_ready
//  result   | result (result_t)                     | out | result_valid / result_ready
//  config   | cfg_index, cfg_data                   | in  | cfg_valid / cfg_ready (=1)
//
//  A word accepted into the input register passes through the state update into the result
//  register; one word per cycle sustained while the result side is not stalled.
//  The state update is a single pass of logic between the input register and the
//  result register, so the input register can take the next word as the current one moves on.
//  A stalled result holds the result register; the input register still takes one word.
//  Reset (rst_n low) returns all timers, the dial machine and config to defaults.

module rotary_dtmf_extension_ringer
    import rdxr_pkg::*;
#(
    parameter int NUM_EXTENSIONS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LINE_COUNT = (NUM_EXTENSIONS > 8) ? 8 : NUM_EXTENSIONS;

    // Configuration
    logic [6:0]  msecs_per_tick_reg;
    logic [9:0]  max_space_reg;
    logic [13:0] ring_msecs_reg;
    logic [13:0] holdoff_reg;

    // Pipeline registers
    logic    in_valid_reg;
    item_t   in_data_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    stage_go;

    // State
    dial_mode_t  dial_reg, dial_next;
    logic [3:0]  count_reg, count_next;
    logic [15:0] on_reg, on_next;
    logic [15:0] off_reg, off_next;
    logic [13:0] ring_reg, ring_next;
    logic [13:0] uptime_reg, uptime_next;
    logic [9:0]  phase_reg, phase_next;
    logic [3:0]  ext_reg, ext_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  lines_reg, lines_next;
    result_t     result_next;

    // Scratch
    logic [10:0] phase_sum;
    logic [16:0] on_sum;
    logic [16:0] off_sum;
    logic [15:0] off_sat;
    logic [3:0]  sel;
    logic        held;

    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // Handshake: stage advances when the result register is free or drained
    always_comb
    begin
        stage_go   = in_valid_reg && (!out_valid_reg || result_ready);
        item_ready = !in_valid_reg || !out_valid_reg || result_ready;
    end

    // Tick processing
    always_comb
    begin
        dial_next   = dial_reg;
        count_next  = count_reg;
        on_next     = on_reg;
        off_next    = off_reg;
        ring_next   = ring_reg;
        uptime_next = uptime_reg;
        phase_next  = phase_reg;
        ext_next    = ext_reg;
        toggle_next = toggle_reg;
        lines_next  = lines_reg;
        sel         = EXT_NONE;
        held        = (dial_reg == DIAL_IDLE) || (dial_reg == DIAL_HELD);
        on_sum      = 17'd0;
        off_sum     = 17'd0;
        off_sat     = 16'd0;

        phase_sum = {1'b0, phase_reg} + {4'd0, msecs_per_tick_reg};

        if (in_data_reg.mode == MODE_MAIN)
        begin
            // wrapping millisecond phase
            if (phase_sum >= PHASE_WRAP)
                phase_next = 10'(phase_sum - PHASE_WRAP);
            else
                phase_next = phase_sum[9:0];

            sel = in_data_reg.tone_strobe ? in_data_reg.tone_code : EXT_NONE;

            // rotary dial machine, frozen while a tone key selects or during the holdoff after reset
            if (sel == EXT_NONE && uptime_reg >= holdoff_reg)
            begin
                if (in_data_reg.pulse_level)
                begin
                    if (held)
                    begin
                        count_next = 4'd0;
                        on_next    = 16'd0;
                        ring_next  = 14'd0;
                    end
                    dial_next = DIAL_PULSE;
                    off_next  = 16'd0;
                    on_sum    = {1'b0, on_next} + {10'd0, msecs_per_tick_reg};
                    on_next   = on_sum[16] ? 16'hFFFF : on_sum[15:0];
                end
                else if (!held)
                begin
                    dial_next = DIAL_SPACE;
                    if (on_reg != 16'd0)
                    begin
                        on_next = 16'd0;
                        if (count_reg < PULSE_COUNT_MAX)
                            count_next = count_reg + 4'd1;
                    end
                    off_sum  = {1'b0, off_reg} + {10'd0, msecs_per_tick_reg};
                    off_sat  = off_sum[16] ? 16'hFFFF : off_sum[15:0];
                    off_next = off_sat;
                    if (off_sat > {6'd0, max_space_reg})
                    begin
                        dial_next = DIAL_HELD;
                        ring_next = ring_msecs_reg;
                    end
                end

                // digit hold period
                if (dial_next == DIAL_HELD && ring_next != 14'd0)
                begin
                    if (ring_next <= {7'd0, msecs_per_tick_reg})
                    begin
                        dial_next  = DIAL_IDLE;
                        count_next = 4'd0;
                        on_next    = 16'd0;
                        off_next   = 16'd0;
                        ring_next  = 14'd0;
                        sel        = EXT_NONE;
                    end
                    else
                    begin
                        ring_next = ring_next - {7'd0, msecs_per_tick_reg};
                        sel       = count_next;
                    end
                end
                else
                begin
                    sel = EXT_NONE;
                end
            end

            ext_next = sel;
            if (uptime_reg < UPTIME_STOP)
                uptime_next = uptime_reg + {7'd0, msecs_per_tick_reg};
        end
        else
        begin
            // buzzer tick: toggle and drive the selected line(s)
            toggle_next = ~toggle_reg;
            lines_next  = 8'd0;
            for (int k = 1; k <= 8; k++)
            begin
                if (k <= LINE_COUNT && (ext_reg == EXT_ALL || ext_reg == 4'(k)))
                    lines_next[k-1] = toggle_next;
            end
        end

        result_next.selected_ext = ext_next;
        result_next.buzzer_lines = lines_next;
        result_next.status_led   = (phase_next <= LED_ON1_END) ||
                                   (phase_next >= LED_ON2_BEG && phase_next <= LED_ON2_END);
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msecs_per_tick_reg <= MSECS_PER_TICK_RST;
            max_space_reg      <= MAX_SPACE_MSECS_RST;
            ring_msecs_reg     <= RING_MSECS_RST;
            holdoff_reg        <= HOLDOFF_MSECS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MSECS_PER_TICK:  msecs_per_tick_reg <= cfg_data[6:0];
                CFG_MAX_SPACE_MSECS: max_space_reg      <= cfg_data[9:0];
                CFG_RING_MSECS:      ring_msecs_reg     <= cfg_data;
                CFG_HOLDOFF_MSECS:   holdoff_reg        <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Input register and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
                in_valid_reg <= 1'b1;
            else if (stage_go)
                in_valid_reg <= 1'b0;

            if (stage_go)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            in_data_reg <= item;
        if (stage_go)
            out_data_reg <= result_next;
    end

    // Ringer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dial_reg   <= DIAL_IDLE;
            count_reg  <= 4'd0;
            on_reg     <= 16'd0;
            off_reg    <= 16'd0;
            ring_reg   <= 14'd0;
            uptime_reg <= 14'd0;
            phase_reg  <= 10'd0;
            ext_reg    <= EXT_NONE;
            toggle_reg <= 1'b0;
            lines_reg  <= 8'd0;
        end
        else if (stage_go)
        begin
            dial_reg   <= dial_next;
            count_reg  <= count_next;
            on_reg     <= on_next;
            off_reg    <= off_next;
            ring_reg   <= ring_next;
            uptime_reg <= uptime_next;
            phase_reg  <= phase_next;
            ext_reg    <= ext_next;
            toggle_reg <= toggle_next;
            lines_reg  <= lines_next;
        end
    end

endmodule

// ===== hdl/rdxr_checker.sv =====
// Checker: port-level properties of the ringer, bound to the top level.
`timescale 1ns / 1ps

module rdxr_checker
    import rdxr_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // A stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // An empty result side never blocks input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input blocked with result register empty");

    // A fresh result comes from an accepted word, which passes the input register first
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready, 2))
        else $error("result appeared without an accepted word");

    // Buzzer lines: none, one, or a contiguous low group for ring-all
    a_lines_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($onehot0(result.buzzer_lines) ||
            ((result.buzzer_lines & (result.buzzer_lines + 8'd1)) == 8'd0)))
        else $error("illegal buzzer line pattern");

endmodule

bind rotary_dtmf_extension_ringer rdxr_checker u_rdxr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
